// File: hdl/c128_pkg.sv
package c128_pkg;

	localparam int unsigned FIFO_DEPTH = 4;

	localparam logic [6:0] START_A   = 7'd103;
	localparam logic [6:0] START_B   = 7'd104;
	localparam logic [6:0] STOP_SYM  = 7'd106;
	localparam logic [6:0] CHECK_MOD = 7'd103;
	localparam logic [6:0] POS_MAX   = 7'd102;
	localparam logic [6:0] RES_A     = 7'(103 % 103);
	localparam logic [6:0] RES_B     = 7'(104 % 103);
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_A_MAX  = 8'd95;
	localparam logic [7:0] CH_B_MAX  = 8'd127;
	localparam logic [7:0] CTRL_OFS  = 8'd64;

	typedef enum logic [1:0] {
		K_CHAR = 2'd0,
		K_BAD  = 2'd1,
		K_END  = 2'd2
	} kind_t;

	typedef struct packed {
		logic       open;
		logic       start_b;
		kind_t      kind;
		logic [6:0] data;
	} qent_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// element widths {bar, space, bar, space, bar, space}, one octal digit each
	localparam logic [17:0] PATTERN [0:106] = '{
		18'o212222, 18'o222122, 18'o222221, 18'o121223, 18'o121322,
		18'o131222, 18'o122213, 18'o122312, 18'o132212, 18'o221213,
		18'o221312, 18'o231212, 18'o112232, 18'o122132, 18'o122231,
		18'o113222, 18'o123122, 18'o123221, 18'o223211, 18'o221132,
		18'o221231, 18'o213212, 18'o223112, 18'o312131, 18'o311222,
		18'o321122, 18'o321221, 18'o312212, 18'o322112, 18'o322211,
		18'o212123, 18'o212321, 18'o232121, 18'o111323, 18'o131123,
		18'o131321, 18'o112313, 18'o132113, 18'o132311, 18'o211313,
		18'o231113, 18'o231311, 18'o112133, 18'o112331, 18'o132131,
		18'o113123, 18'o113321, 18'o133121, 18'o313121, 18'o211331,
		18'o231131, 18'o213113, 18'o213311, 18'o213131, 18'o311123,
		18'o311321, 18'o331121, 18'o312113, 18'o312311, 18'o332111,
		18'o314111, 18'o221411, 18'o431111, 18'o111224, 18'o111422,
		18'o121124, 18'o121421, 18'o141122, 18'o141221, 18'o112214,
		18'o112412, 18'o122114, 18'o122411, 18'o142112, 18'o142211,
		18'o241211, 18'o221114, 18'o413111, 18'o241112, 18'o134111,
		18'o111242, 18'o121142, 18'o121241, 18'o114212, 18'o124112,
		18'o124211, 18'o411212, 18'o421112, 18'o421211, 18'o212141,
		18'o214121, 18'o412121, 18'o111143, 18'o111341, 18'o131141,
		18'o114113, 18'o114311, 18'o411113, 18'o411311, 18'o113141,
		18'o114131, 18'o311141, 18'o411131, 18'o211412, 18'o211214,
		18'o211232, 18'o233111
	};

	function automatic logic [17:0] sym_pattern(input logic [6:0] v);
		logic [17:0] p;
		p = '0;
		if (v <= STOP_SYM) begin
			p = PATTERN[v];
		end
		return p;
	endfunction

	// remainder modulo 103 of a product below 103*128, by restoring subtraction
	function automatic logic [6:0] mod103(input logic [13:0] x);
		logic [13:0] t;
		logic [13:0] m;
		t = x;
		for (int k = 6; k >= 0; k--) begin
			m = {7'd0, CHECK_MOD} << k;
			if (t >= m) begin
				t = t - m;
			end
		end
		return t[6:0];
	endfunction

endpackage

// File: hdl/c128_if.sv
interface c128_in_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] char_code;

	modport source(output valid, output mode, output char_code, input ready);
	modport sink(input valid, input mode, input char_code, output ready);
endinterface

interface c128_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] symbol_value;
	logic [2:0] bar_one;
	logic [2:0] space_one;
	logic [2:0] bar_two;
	logic [2:0] space_two;
	logic [2:0] bar_three;
	logic [2:0] space_three;
	logic [1:0] bar_four;
	logic       bad_char;
	logic       last;

	modport source(output valid, output symbol_value, output bar_one, output space_one,
		output bar_two, output space_two, output bar_three, output space_three,
		output bar_four, output bad_char, output last, input ready);
	modport sink(input valid, input symbol_value, input bar_one, input space_one,
		input bar_two, input space_two, input bar_three, input space_three,
		input bar_four, input bad_char, input last, output ready);
endinterface

// File: hdl/c128_front.sv
module c128_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 subset,
	c128_in_if.sink              in_ch,
	input  c128_pkg::fifo_stat_t fstat,
	output logic                 push,
	output c128_pkg::qent_t      push_data
);

	logic adv;
	logic take;

	logic       in_msg_q;
	logic       ab_q;
	logic [6:0] pos_q;
	logic [6:0] acc_q;

	logic              emit;
	logic              open;
	c128_pkg::kind_t   kind;
	logic [6:0]        val;
	logic [6:0]        wgt;
	logic              in_msg_d;
	logic              ab_d;
	logic [6:0]        pos_d;
	logic              ok;
	logic [6:0]        cval;

	logic              v_s1, open_s1, sb_s1;
	c128_pkg::kind_t   kind_s1;
	logic [6:0]        val_s1, wgt_s1;
	logic              v_s2, open_s2, sb_s2;
	c128_pkg::kind_t   kind_s2;
	logic [6:0]        val_s2;
	logic [13:0]       prod_s2;
	logic              v_s3, open_s3, sb_s3;
	c128_pkg::kind_t   kind_s3;
	logic [6:0]        val_s3, rem_s3;

	logic [6:0] base;
	logic [7:0] sum;
	logic [6:0] chk;

	assign adv         = !v_s3 || !fstat.full;
	assign in_ch.ready = adv;
	assign take        = in_ch.valid && adv;

	always_comb begin
		if (subset == 1'b0) begin
			ok   = in_ch.char_code <= c128_pkg::CH_A_MAX;
			cval = (in_ch.char_code >= c128_pkg::CH_SPACE)
				? 7'(in_ch.char_code - c128_pkg::CH_SPACE)
				: 7'(in_ch.char_code + c128_pkg::CTRL_OFS);
		end else begin
			ok   = (in_ch.char_code >= c128_pkg::CH_SPACE)
				&& (in_ch.char_code <= c128_pkg::CH_B_MAX);
			cval = 7'(in_ch.char_code - c128_pkg::CH_SPACE);
		end
	end

	always_comb begin
		emit     = 1'b0;
		open     = !in_msg_q;
		kind     = c128_pkg::K_CHAR;
		val      = '0;
		wgt      = open ? 7'd1 : pos_q;
		in_msg_d = in_msg_q;
		ab_d     = ab_q;
		pos_d    = pos_q;
		if (in_ch.mode) begin
			emit     = !(in_msg_q && ab_q);
			kind     = c128_pkg::K_END;
			in_msg_d = 1'b0;
			ab_d     = 1'b0;
			pos_d    = '0;
		end else if (!(in_msg_q && ab_q)) begin
			emit     = 1'b1;
			in_msg_d = 1'b1;
			if (ok) begin
				val   = cval;
				ab_d  = 1'b0;
				pos_d = (wgt == c128_pkg::POS_MAX) ? 7'd0 : wgt + 7'd1;
			end else begin
				kind  = c128_pkg::K_BAD;
				ab_d  = 1'b1;
				pos_d = wgt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q <= 1'b0;
			ab_q     <= 1'b0;
			pos_q    <= '0;
		end else if (take) begin
			in_msg_q <= in_msg_d;
			ab_q     <= ab_d;
			pos_q    <= pos_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= take && emit;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			open_s1 <= open;
			sb_s1   <= subset;
			kind_s1 <= kind;
			val_s1  <= val;
			wgt_s1  <= wgt;
			open_s2 <= open_s1;
			sb_s2   <= sb_s1;
			kind_s2 <= kind_s1;
			val_s2  <= val_s1;
			prod_s2 <= {7'd0, val_s1} * {7'd0, wgt_s1};
			open_s3 <= open_s2;
			sb_s3   <= sb_s2;
			kind_s3 <= kind_s2;
			val_s3  <= val_s2;
			rem_s3  <= c128_pkg::mod103(prod_s2);
		end
	end

	// checksum restarts from the start symbol's residue when a message opens
	always_comb begin
		if (open_s3) begin
			base = sb_s3 ? c128_pkg::RES_B : c128_pkg::RES_A;
		end else begin
			base = acc_q;
		end
		sum = {1'b0, base} + {1'b0, rem_s3};
		chk = (sum >= {1'b0, c128_pkg::CHECK_MOD}) ? 7'(sum - {1'b0, c128_pkg::CHECK_MOD})
			: sum[6:0];
	end

	assign push              = v_s3 && adv;
	assign push_data.open    = open_s3;
	assign push_data.start_b = sb_s3;
	assign push_data.kind    = kind_s3;
	assign push_data.data    = (kind_s3 == c128_pkg::K_END) ? base : val_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (push && kind_s3 == c128_pkg::K_CHAR) begin
			acc_q <= chk;
		end
	end

endmodule

// File: hdl/c128_fifo.sv
module c128_fifo #(
	parameter int unsigned DEPTH = c128_pkg::FIFO_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  c128_pkg::qent_t      push_data,
	input  logic                 pop,
	output c128_pkg::qent_t      head,
	output c128_pkg::fifo_stat_t fstat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	c128_pkg::qent_t mem_q [0:DEPTH-1];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign fstat.full  = count_q == CW'(DEPTH);
	assign fstat.empty = count_q == '0;
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/c128_back.sv
module c128_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  c128_pkg::qent_t      head,
	input  c128_pkg::fifo_stat_t fstat,
	output logic                 pop,
	c128_out_if.source           out_ch
);

	typedef enum logic [2:0] {
		PH_START = 3'b001,
		PH_MAIN  = 3'b010,
		PH_STOP  = 3'b100
	} phase_t;

	phase_t      phase_q;
	phase_t      cur;
	phase_t      nxt;
	logic        load;
	logic [6:0]  sym;
	logic        err;
	logic        last;
	logic [17:0] pat;

	logic        out_v_q;
	logic [6:0]  sym_q;
	logic [17:0] pat_q;
	logic [1:0]  b4_q;
	logic        err_q;
	logic        last_q;

	// skip the start phase for entries that continue an open message
	always_comb begin
		cur = phase_q;
		if (phase_q == PH_START && !head.open) begin
			cur = PH_MAIN;
		end
	end

	always_comb begin
		sym  = '0;
		err  = 1'b0;
		last = 1'b0;
		nxt  = PH_START;
		unique case (cur)
			PH_START: begin
				sym = head.start_b ? c128_pkg::START_B : c128_pkg::START_A;
				nxt = PH_MAIN;
			end
			PH_MAIN: begin
				sym  = head.data;
				err  = head.kind == c128_pkg::K_BAD;
				last = head.kind != c128_pkg::K_END;
				nxt  = last ? PH_START : PH_STOP;
				if (err) begin
					sym = '0;
				end
			end
			PH_STOP: begin
				sym  = c128_pkg::STOP_SYM;
				last = 1'b1;
			end
			default: begin
				sym = '0;
			end
		endcase
		pat = err ? 18'd0 : c128_pkg::sym_pattern(sym);
	end

	assign load = !fstat.empty && (!out_v_q || out_ch.ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				phase_q <= nxt;
			end
			if (load) begin
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sym_q  <= sym;
			pat_q  <= pat;
			b4_q   <= (cur == PH_STOP) ? 2'd2 : 2'd0;
			err_q  <= err;
			last_q <= last;
		end
	end

	assign out_ch.valid        = out_v_q;
	assign out_ch.symbol_value = sym_q;
	assign out_ch.bar_one      = pat_q[17:15];
	assign out_ch.space_one    = pat_q[14:12];
	assign out_ch.bar_two      = pat_q[11:9];
	assign out_ch.space_two    = pat_q[8:6];
	assign out_ch.bar_three    = pat_q[5:3];
	assign out_ch.space_three  = pat_q[2:0];
	assign out_ch.bar_four     = b4_q;
	assign out_ch.bad_char     = err_q;
	assign out_ch.last         = last_q;

endmodule

// File: hdl/code128_symbol_encoder.sv
// channel   dir  payload                                            handshake
// in_ch     in   mode, char_code                                    valid/ready
// out_ch    out  symbol_value, six widths, bar_four, bad_char, last valid/ready
// subset    cfg  subset_wd (1 bit)                                  subset_we
//
// Front end takes one transaction per cycle; its three-stage checksum pipe
// (weight multiply, mod-103 reduction, accumulate) feeds the symbol queue.
// Back end emits one symbol per cycle unless the queue is empty or the output
// stalls: 1 per character or error, 2 if it opens a message, 2 or 3 per end mark.
// Reset selects subset B and closes any open message; no clearing pass.
// A stalled output holds in its register while the queue keeps filling; the
// front end stalls only when the queue is full.
module code128_symbol_encoder #(
	parameter int unsigned FIFO_DEPTH = c128_pkg::FIFO_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	c128_in_if.sink     in_ch,
	c128_out_if.source  out_ch,
	input  logic        subset_we,
	input  logic        subset_wd
);

	logic                 subset_q;
	logic                 push;
	logic                 pop;
	c128_pkg::qent_t      push_data;
	c128_pkg::qent_t      head;
	c128_pkg::fifo_stat_t fstat;

	// hold the subset select; the user must write it only while the block is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			subset_q <= 1'b1;
		end else if (subset_we) begin
			subset_q <= subset_wd;
		end
	end

	// classify characters, track position, accumulate the checksum
	c128_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.subset    (subset_q),
		.in_ch     (in_ch),
		.fstat     (fstat),
		.push      (push),
		.push_data (push_data)
	);

	// decouple classification from symbol emission
	c128_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.fstat     (fstat)
	);

	// expand each queued entry into start, body and stop symbols
	c128_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.fstat  (fstat),
		.pop    (pop),
		.out_ch (out_ch)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && fstat.full))
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && fstat.empty))
		else $error("queue read while empty");

	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.bad_char |-> out_ch.last && out_ch.symbol_value == 7'd0)
		else $error("error result malformed");

	a_stop_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.symbol_value == c128_pkg::STOP_SYM
		|-> out_ch.last && out_ch.bar_four == 2'd2)
		else $error("stop symbol not closing the run");
`endif

endmodule

// File: tb/sv/tb_code128_symbol_encoder.sv
module tb_code128_symbol_encoder;
	timeunit 1ns;
	timeprecision 1ps;

	// item kinds on the input channel
	localparam bit MODE_CHAR = 1'b0;
	localparam bit MODE_END  = 1'b1;

	// values of the subset register
	localparam bit SUBSET_A = 1'b0;
	localparam bit SUBSET_B = 1'b1;

	localparam int MAX_REPORTS   = 10;
	// cycles to let the front-end pipe empty after the last symbol arrives;
	// a dropped character or an aborted end mark leaves nothing to wait on
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 80;
	localparam int DRAIN_LIMIT   = 20000;

	// one emitted symbol, laid out field for field like the output channel
	typedef struct packed {
		logic [6:0] symbol_value;
		logic [2:0] bar_one;
		logic [2:0] space_one;
		logic [2:0] bar_two;
		logic [2:0] space_two;
		logic [2:0] bar_three;
		logic [2:0] space_three;
		logic [1:0] bar_four;
		logic       bad_char;
		logic       last;
	} symbol_t;

	// module widths of symbols 0..105 as six decimal digits, bar first
	localparam int unsigned WIDTH_CODES [0:105] = '{
		212222, 222122, 222221, 121223, 121322, 131222, 122213, 122312, 132212, 221213,
		221312, 231212, 112232, 122132, 122231, 113222, 123122, 123221, 223211, 221132,
		221231, 213212, 223112, 312131, 311222, 321122, 321221, 312212, 322112, 322211,
		212123, 212321, 232121, 111323, 131123, 131321, 112313, 132113, 132311, 211313,
		231113, 231311, 112133, 112331, 132131, 113123, 113321, 133121, 313121, 211331,
		231131, 213113, 213311, 213131, 311123, 311321, 331121, 312113, 312311, 332111,
		314111, 221411, 431111, 111224, 111422, 121124, 121421, 141122, 141221, 112214,
		112412, 122114, 122411, 142112, 142211, 241211, 221114, 413111, 241112, 134111,
		111242, 121142, 121241, 114212, 124112, 124211, 411212, 421112, 421211, 212141,
		214121, 412121, 111143, 111341, 131141, 114113, 114311, 411113, 411311, 113141,
		114131, 311141, 411131, 211412, 211214, 211232
	};

	// Tracks the message state of the encoder and keeps the symbols still owed.
	class symbol_scoreboard;
		bit      subset_b;
		int      check_sum;
		int      weight;
		bit      open_msg;
		bit      dropping;
		symbol_t expected_q[$];
		int      mismatches;
		int      items_seen;
		int      marks_seen;
		int      symbols_checked;

		function new();
			subset_b = SUBSET_B;
			close_message();
		endfunction

		function void close_message();
			open_msg  = 1'b0;
			dropping  = 1'b0;
			check_sum = 0;
			weight    = 0;
		endfunction

		function symbol_t make_symbol(int v);
			symbol_t     s;
			int unsigned p;
			s = '0;
			if (v >= int'(c128_pkg::STOP_SYM)) begin
				s.symbol_value = c128_pkg::STOP_SYM;
				{s.bar_one, s.space_one, s.bar_two} = {3'd2, 3'd3, 3'd3};
				{s.space_two, s.bar_three, s.space_three} = {3'd1, 3'd1, 3'd1};
				s.bar_four = 2'd2;
			end else begin
				p = WIDTH_CODES[v];
				s.symbol_value = 7'(v);
				s.space_three = 3'(p % 10); p = p / 10;
				s.bar_three   = 3'(p % 10); p = p / 10;
				s.space_two   = 3'(p % 10); p = p / 10;
				s.bar_two     = 3'(p % 10); p = p / 10;
				s.space_one   = 3'(p % 10); p = p / 10;
				s.bar_one     = 3'(p % 10);
			end
			return s;
		endfunction

		// emit the start symbol from the subset in force at the first item
		function void open_message();
			int start;
			start = subset_b ? int'(c128_pkg::START_B) : int'(c128_pkg::START_A);
			expected_q.push_back(make_symbol(start));
			check_sum = start % int'(c128_pkg::CHECK_MOD);
			weight    = 1;
			open_msg  = 1'b1;
			dropping  = 1'b0;
		endfunction

		function void note_item(bit mode, bit [7:0] ch);
			int      n0;
			int      val;
			bit      ok;
			symbol_t err;
			n0 = expected_q.size();
			items_seen++;
			if (mode == MODE_END) begin
				marks_seen++;
				// an aborted message closes silently
				if (open_msg && dropping) begin
					close_message();
					return;
				end
				if (!open_msg) open_message();
				expected_q.push_back(make_symbol(check_sum));
				expected_q.push_back(make_symbol(int'(c128_pkg::STOP_SYM)));
				close_message();
			end else begin
				if (open_msg && dropping) return;
				if (!open_msg) open_message();
				if (subset_b == SUBSET_A) begin
					ok  = ch <= c128_pkg::CH_A_MAX;
					val = (ch >= c128_pkg::CH_SPACE) ? int'(ch) - int'(c128_pkg::CH_SPACE)
						: int'(ch) + int'(c128_pkg::CTRL_OFS);
				end else begin
					ok  = ch >= c128_pkg::CH_SPACE && ch <= c128_pkg::CH_B_MAX;
					val = int'(ch) - int'(c128_pkg::CH_SPACE);
				end
				if (ok) begin
					check_sum = (check_sum + val * weight) % int'(c128_pkg::CHECK_MOD);
					weight    = (weight + 1) % int'(c128_pkg::CHECK_MOD);
					expected_q.push_back(make_symbol(val));
				end else begin
					dropping = 1'b1;
					err = '0;
					err.bad_char = 1'b1;
					expected_q.push_back(err);
				end
			end
			if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
		endfunction

		function string show(symbol_t s);
			return $sformatf("sym=%0d w=%0d%0d%0d%0d%0d%0d b4=%0d bad=%0b last=%0b",
				s.symbol_value, s.bar_one, s.space_one, s.bar_two, s.space_two,
				s.bar_three, s.space_three, s.bar_four, s.bad_char, s.last);
		endfunction

		function void check_result(symbol_t got);
			symbol_t want;
			symbols_checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected symbol %s", $time, show(got));
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: symbol mismatch\n  expected %s\n  actual   %s",
						$time, show(want), show(got));
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic subset_we;
	logic subset_wd;

	c128_in_if  in_if();
	c128_out_if out_if();

	code128_symbol_encoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_if),
		.out_ch    (out_if),
		.subset_we (subset_we),
		.subset_wd (subset_wd)
	);

	symbol_scoreboard sb = new();

	// sender burst bookkeeping
	int burst_left;
	// long receiver hold-offs requested by the stimulus, and those served
	int hold_reqs;
	int hold_served;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#400_000;
		$display("timeout with %0d symbols outstanding", sb.pending());
		$display("tb_code128_symbol_encoder: done, errors");
		$finish;
	end

	// Watch both channels at the edge. Note the input before checking the output
	// so that a same-edge pair is always handled in causal order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_if.valid && in_if.ready)
				sb.note_item(in_if.mode, in_if.char_code);
			if (out_if.valid && out_if.ready)
				sb.check_result({out_if.symbol_value, out_if.bar_one, out_if.space_one,
					out_if.bar_two, out_if.space_two, out_if.bar_three, out_if.space_three,
					out_if.bar_four, out_if.bad_char, out_if.last});
		end
	end

	// Receiver: ready follows a rotating stall mask that changes at the end of each
	// random stretch; a quarter of the stretches take everything. A requested hold
	// drops ready for a long, counted stretch.
	initial begin
		int          hold_left;
		int          stretch;
		logic [7:0]  stall_mask;
		hold_left = 0;
		stretch   = 0;
		stall_mask = 8'hFF;
		hold_served = 0;
		out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_served) begin
				hold_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_if.ready <= 1'b0;
			end else begin
				if (stretch == 0) begin
					stretch = $urandom_range(20, 60);
					stall_mask = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
				end
				stretch--;
				out_if.ready <= stall_mask[stretch % 8];
			end
		end
	end

	// Offer one transaction and hold it until accepted. Between bursts, drop
	// valid for a random gap first.
	task automatic offer(input bit mode, input logic [7:0] ch);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_if.valid     <= 1'b1;
		in_if.mode      <= mode;
		in_if.char_code <= ch;
		do @(posedge clk); while (!in_if.ready);
	endtask

	// Stop sending, wait for every owed symbol, then let the pipe settle.
	task automatic drain_and_settle();
		int waited;
		waited = 0;
		in_if.valid <= 1'b0;
		// let the monitor note the transaction accepted at the last edge
		@(posedge clk);
		while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; only called while the block is idle.
	task automatic write_subset(input bit value);
		subset_we <= 1'b1;
		subset_wd <= value;
		@(posedge clk);
		subset_we <= 1'b0;
		sb.subset_b = value;
	endtask

	// A message of len characters, mostly valid for the current subset; bad_pct
	// percent are raw bytes that may abort the message.
	task automatic send_message(input int len, input int bad_pct);
		logic [7:0] ch;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < bad_pct)
				ch = 8'($urandom_range(0, 255));
			else if (sb.subset_b == SUBSET_A)
				ch = 8'($urandom_range(0, 95));
			else
				ch = 8'($urandom_range(32, 127));
			offer(MODE_CHAR, ch);
		end
		offer(MODE_END, 8'($urandom));
	endtask

	initial begin
		int choice;
		burst_left = 0;
		hold_reqs  = 0;
		arst_n          <= 1'b0;
		subset_we       <= 1'b0;
		subset_wd       <= 1'b0;
		in_if.valid     <= 1'b0;
		in_if.mode      <= MODE_CHAR;
		in_if.char_code <= 8'd0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, subset B out of reset.
		// End mark with nothing open: start, checksum, stop.
		offer(MODE_END, 8'hFF);
		// Range ends of subset B.
		offer(MODE_CHAR, 8'd32);
		offer(MODE_CHAR, 8'd127);
		offer(MODE_CHAR, 8'd65);
		offer(MODE_END, 8'h00);
		// Bad first character: start then error; rest dropped, end mark silent.
		offer(MODE_CHAR, 8'd31);
		offer(MODE_CHAR, 8'd200);
		offer(MODE_CHAR, 8'd64);
		offer(MODE_END, 8'h55);
		// Bad character mid-message.
		offer(MODE_CHAR, 8'd100);
		offer(MODE_CHAR, 8'd128);
		offer(MODE_CHAR, 8'd50);
		offer(MODE_END, 8'hAA);
		drain_and_settle();

		// Subset A: controls map above the printables.
		write_subset(SUBSET_A);
		offer(MODE_CHAR, 8'd0);
		offer(MODE_CHAR, 8'd31);
		offer(MODE_CHAR, 8'd95);
		offer(MODE_CHAR, 8'd32);
		offer(MODE_END, 8'd0);
		offer(MODE_CHAR, 8'd96);
		offer(MODE_END, 8'd0);
		// Leave a message open in A, then switch to B: start keeps A, later
		// characters follow B.
		offer(MODE_CHAR, 8'd10);
		drain_and_settle();
		write_subset(SUBSET_B);
		offer(MODE_CHAR, 8'd100);
		offer(MODE_CHAR, 8'd5);
		offer(MODE_END, 8'd0);

		// Random phases, each one starting from idle with a fresh subset.
		for (int phase = 0; phase < 4; phase++) begin
			drain_and_settle();
			case (phase)
				0: write_subset(SUBSET_A);
				1: write_subset(SUBSET_B);
				2: write_subset(SUBSET_A);
				default: write_subset(1'($urandom));
			endcase
			if (phase == 1) begin
				// Stall the output for a long stretch while feeding back-to-back,
				// so the queue fills and the input backs up.
				hold_reqs <= hold_reqs + 1;
				burst_left = 20;
				send_message(16, 0);
			end
			repeat (4) begin
				choice = $urandom_range(0, 9);
				case (choice)
					0: offer(MODE_END, 8'($urandom));
					1: send_message($urandom_range(1, 6), 40);
					default: send_message($urandom_range(0, 7), 4);
				endcase
			end
		end

		drain_and_settle();
		if (sb.pending() != 0) begin
			sb.mismatches++;
			$display("%0d expected symbols never arrived", sb.pending());
		end
		$display("run covered %0d input transactions (%0d end marks) in subsets A and B,",
			sb.items_seen, sb.marks_seen);
		$display("  %0d symbols checked, %0d mismatches", sb.symbols_checked, sb.mismatches);
		if (sb.mismatches == 0) begin
			$display("tb_code128_symbol_encoder: done, clean");
		end else begin
			$display("tb_code128_symbol_encoder: done, errors");
		end
		$finish;
	end
endmodule

// File: code128_symbol_encoder.f
hdl/c128_pkg.sv
hdl/c128_if.sv
hdl/c128_front.sv
hdl/c128_fifo.sv
hdl/c128_back.sv
hdl/code128_symbol_encoder.sv
tb/sv/tb_code128_symbol_encoder.sv
